// File: rtl/core/slrl_pkg.sv
package slrl_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int LOG_DEPTH = 64;
    localparam int TIME_BITS = 32;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int PTR_W  = $clog2(LOG_DEPTH);
    localparam int FILL_W = $clog2(LOG_DEPTH + 1);
    localparam int REQ_W  = 2;
    localparam int MAX_W  = 7;
    localparam int WIN_W  = 32;

    // APB register map
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_IDX_BIT  = 2;
    localparam logic REG_WINDOW_TICKS = 1'b0;
    localparam logic REG_MAX_MESSAGES = 1'b1;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000);
    localparam logic [MAX_W-1:0] MAX_RESET    = MAX_W'(10);

    typedef enum logic [REQ_W-1:0] {
        REQ_RECORD  = 2'd0,
        REQ_CHECK   = 2'd1,
        REQ_REMOVE  = 2'd2,
        REQ_CLEANUP = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SLOT,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic record;
        logic remove;
        logic slot_sel_req;
        logic slot_first;
        logic slot_next;
        logic walk_init;
        logic walk_run;
        logic commit_fill;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        req_t req_type;
        logic present;
        logic walk_done;
        logic last_slot;
    } status_t;

endpackage

// File: rtl/core/slrl_if.sv
interface slrl_req_if import slrl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [SLOT_W-1:0]    client_slot;
    logic [TIME_BITS-1:0] now_ticks;

    modport source (output valid, output req_type, output client_slot, output now_ticks,
                    input ready);
    modport sink   (input valid, input req_type, input client_slot, input now_ticks,
                    output ready);
endinterface

interface slrl_rsp_if import slrl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              limited;
    logic [FILL_W-1:0] in_window_count;
    logic              entry_present;

    modport source (output valid, output limited, output in_window_count,
                    output entry_present, input ready);
    modport sink   (input valid, input limited, input in_window_count,
                    input entry_present, output ready);
endinterface

// File: rtl/core/slrl_cfg.sv
module slrl_cfg import slrl_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [WIN_W-1:0]      window_ticks,
    output logic [MAX_W-1:0]      max_messages
);

    logic [WIN_W-1:0] window_reg;
    logic [MAX_W-1:0] max_reg;
    logic             wr_en;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_IDX_BIT];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            max_reg    <= MAX_RESET;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_WINDOW_TICKS)
            begin
                window_reg <= pwdata[WIN_W-1:0];
            end
            else
            begin
                max_reg <= pwdata[MAX_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WINDOW_TICKS: prdata = CFG_DATA_W'(window_reg);
            REG_MAX_MESSAGES: prdata = CFG_DATA_W'(max_reg);
            default:          prdata = '0;
        endcase
    end

    assign window_ticks = window_reg;
    assign max_messages = max_reg;

endmodule

// File: rtl/core/slrl_datapath.sv
module slrl_datapath import slrl_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [SLOT_W-1:0]    client_slot,
    input  logic [TIME_BITS-1:0] now_ticks,
    input  logic [WIN_W-1:0]     window_ticks,
    input  logic [MAX_W-1:0]     max_messages,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic                 limited,
    output logic [FILL_W-1:0]    in_window_count,
    output logic                 entry_present
);

    // circular position: base plus offset, modulo the log depth
    function automatic logic [PTR_W-1:0] log_pos(input logic [PTR_W-1:0] base,
                                                 input logic [FILL_W-1:0] off);
        logic [FILL_W:0] sum;
        sum = (FILL_W + 1)'(base) + (FILL_W + 1)'(off);
        if (sum >= (FILL_W + 1)'(LOG_DEPTH))
        begin
            sum = sum - (FILL_W + 1)'(LOG_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // captured item
    req_t                 req_type_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 present_reg;

    // per-slot bookkeeping
    logic                 present_arr_reg [NUM_SLOTS];
    logic [PTR_W-1:0]     ptr_arr_reg     [NUM_SLOTS];
    logic [FILL_W-1:0]    fill_arr_reg    [NUM_SLOTS];

    // log memory, one write and one read port
    logic [TIME_BITS-1:0] log_mem [NUM_SLOTS][LOG_DEPTH];

    // walk engine
    logic [SLOT_W-1:0]    walk_slot_reg;
    logic [FILL_W-1:0]    k_reg;
    logic [FILL_W-1:0]    hits_reg;
    logic                 rd_valid_reg;
    logic [TIME_BITS-1:0] rd_data_reg;

    // result
    logic                 limited_reg;
    logic [FILL_W-1:0]    count_reg;
    logic                 entry_present_reg;

    logic [PTR_W-1:0]     walk_ptr;
    logic [FILL_W-1:0]    walk_fill;
    logic                 issue;
    logic [PTR_W-1:0]     rd_pos;
    logic [TIME_BITS-1:0] age;
    logic                 hit;
    logic                 clean_wr;
    logic [PTR_W-1:0]     clean_pos;
    logic [PTR_W-1:0]     rec_ptr;
    logic [FILL_W-1:0]    rec_fill;
    logic                 rec_present;
    logic [PTR_W-1:0]     rec_pos;
    logic [PTR_W-1:0]     rec_ptr_next;
    logic [FILL_W-1:0]    rec_fill_next;
    logic                 check_hit;

    always_comb
    begin
        walk_ptr  = ptr_arr_reg[walk_slot_reg];
        walk_fill = fill_arr_reg[walk_slot_reg];
        issue     = cmd.walk_run && (k_reg < walk_fill);
        rd_pos    = log_pos(walk_ptr, k_reg);
        age       = now_reg - rd_data_reg;
        hit       = rd_valid_reg && (age <= TIME_BITS'(window_ticks));
        clean_wr  = hit && (req_type_reg == REQ_CLEANUP);
        clean_pos = log_pos(walk_ptr, hits_reg);
        check_hit = (req_type_reg == REQ_CHECK) && present_reg;
    end

    // append position; a full log overwrites its oldest time
    always_comb
    begin
        rec_ptr     = ptr_arr_reg[slot_reg];
        rec_fill    = fill_arr_reg[slot_reg];
        rec_present = present_arr_reg[slot_reg];
        if (!rec_present)
        begin
            rec_pos       = '0;
            rec_ptr_next  = '0;
            rec_fill_next = FILL_W'(1);
        end
        else if (rec_fill == FILL_W'(LOG_DEPTH))
        begin
            rec_pos       = rec_ptr;
            rec_ptr_next  = log_pos(rec_ptr, FILL_W'(1));
            rec_fill_next = rec_fill;
        end
        else
        begin
            rec_pos       = log_pos(rec_ptr, rec_fill);
            rec_ptr_next  = rec_ptr;
            rec_fill_next = rec_fill + FILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= req_t'(req_type);
            slot_reg     <= client_slot;
            now_reg      <= now_ticks;
            present_reg  <= present_arr_reg[client_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.record)
        begin
            log_mem[slot_reg][rec_pos] <= now_reg;
        end
        else if (clean_wr)
        begin
            log_mem[walk_slot_reg][clean_pos] <= rd_data_reg;
        end
        if (issue)
        begin
            rd_data_reg <= log_mem[walk_slot_reg][rd_pos];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                present_arr_reg[i] <= 1'b0;
                ptr_arr_reg[i]     <= '0;
                fill_arr_reg[i]    <= '0;
            end
        end
        else if (cmd.record)
        begin
            present_arr_reg[slot_reg] <= 1'b1;
            ptr_arr_reg[slot_reg]     <= rec_ptr_next;
            fill_arr_reg[slot_reg]    <= rec_fill_next;
        end
        else if (cmd.remove)
        begin
            present_arr_reg[slot_reg] <= 1'b0;
            ptr_arr_reg[slot_reg]     <= '0;
            fill_arr_reg[slot_reg]    <= '0;
        end
        else if (cmd.commit_fill)
        begin
            fill_arr_reg[walk_slot_reg] <= hits_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_slot_reg <= '0;
            k_reg         <= '0;
            hits_reg      <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.slot_sel_req)
            begin
                walk_slot_reg <= slot_reg;
            end
            else if (cmd.slot_first)
            begin
                walk_slot_reg <= '0;
            end
            else if (cmd.slot_next)
            begin
                walk_slot_reg <= walk_slot_reg + SLOT_W'(1);
            end

            if (cmd.walk_init)
            begin
                k_reg    <= '0;
                hits_reg <= '0;
            end
            else
            begin
                if (issue)
                begin
                    k_reg <= k_reg + FILL_W'(1);
                end
                if (hit)
                begin
                    hits_reg <= hits_reg + FILL_W'(1);
                end
            end

            rd_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            limited_reg       <= check_hit && (hits_reg >= FILL_W'(max_messages));
            count_reg         <= check_hit ? hits_reg : '0;
            entry_present_reg <= present_reg;
        end
    end

    assign status.req_type  = req_type_reg;
    assign status.present   = present_reg;
    assign status.walk_done = (k_reg >= walk_fill) && !rd_valid_reg;
    assign status.last_slot = (walk_slot_reg == SLOT_W'(NUM_SLOTS - 1));

    assign limited         = limited_reg;
    assign in_window_count = count_reg;
    assign entry_present   = entry_present_reg;

endmodule

// File: rtl/core/slrl_ctrl.sv
module slrl_ctrl import slrl_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (status.req_type)
                    REQ_CHECK:   state_next = status.present ? ST_WALK : ST_DONE;
                    REQ_CLEANUP: state_next = ST_SLOT;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_SLOT:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (status.walk_done)
                begin
                    if ((status.req_type == REQ_CLEANUP) && !status.last_slot)
                    begin
                        state_next = ST_SLOT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC:
            begin
                case (status.req_type)
                    REQ_RECORD:  cmd.record = 1'b1;
                    REQ_REMOVE:  cmd.remove = 1'b1;
                    REQ_CHECK:
                    begin
                        cmd.slot_sel_req = status.present;
                        cmd.walk_init    = status.present;
                    end
                    REQ_CLEANUP: cmd.slot_first = 1'b1;
                    default:     cmd.record = 1'b0;
                endcase
            end
            ST_SLOT:
            begin
                cmd.walk_init = 1'b1;
            end
            ST_WALK:
            begin
                cmd.walk_run = 1'b1;
                if (status.walk_done && (status.req_type == REQ_CLEANUP))
                begin
                    cmd.commit_fill = 1'b1;
                    cmd.slot_next   = !status.last_slot;
                end
            end
            ST_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/sliding_log_rate_limiter.sv
// Per-client sliding-log rate limiter for 16 client slots, each with a circular
// log of up to 64 message times held in a 1024 x 32 log memory (one write and
// one registered read port; its contents are never cleared, only the per-slot
// fill counts are). One request is handled at a time and gives one response.
// A check on a present slot walks its log, reading one logged time per cycle
// through the memory read port; cleanup walks every slot in turn. A new
// request is taken while the previous response still waits in the output
// register. Times are compared as (now - t) modulo 2^32 against window_ticks;
// registers live at byte 0 (window_ticks) and 4 (max_messages) and may be
// written only while the block is idle.
module sliding_log_rate_limiter import slrl_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    slrl_req_if.sink              req,
    slrl_rsp_if.source            rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [WIN_W-1:0] window_ticks;
    logic [MAX_W-1:0] max_messages;
    cmd_t             cmd;
    status_t          status;

    slrl_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .window_ticks (window_ticks),
        .max_messages (max_messages)
    );

    slrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    slrl_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_type        (req.req_type),
        .client_slot     (req.client_slot),
        .now_ticks       (req.now_ticks),
        .window_ticks    (window_ticks),
        .max_messages    (max_messages),
        .cmd             (cmd),
        .status          (status),
        .limited         (rsp.limited),
        .in_window_count (rsp.in_window_count),
        .entry_present   (rsp.entry_present)
    );

    // a count can never exceed the log depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.in_window_count <= FILL_W'(LOG_DEPTH)))
        else $error("in_window_count above log depth");

    // only a present slot can be limited
    a_limited_present: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.limited) |-> rsp.entry_present)
        else $error("limited reported for absent slot");

    // a transaction takes the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while busy");

    // a new response is loaded only after the previous one has been taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.in_window_count)))
        else $error("pending response overwritten");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import slrl_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int LIMIT_CYCLES  = 4_000_000;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 100;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic              limited;
        logic [FILL_W-1:0] count;
        logic              present;
    } verdict_t;

    typedef struct {
        req_t                 op;
        logic [SLOT_W-1:0]    slot;
        logic [TIME_BITS-1:0] now;
        bit                   typed;
        verdict_t             want;
    } directed_row_t;

    typedef struct {
        logic [WIN_W-1:0] window;
        logic [MAX_W-1:0] max_msgs;
        int               send_idle;
        int               recv_idle;
    } phase_cfg_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    slrl_req_if req_if ();
    slrl_rsp_if rsp_if ();

    sliding_log_rate_limiter u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the limiter state
    logic [WIN_W-1:0]     win_ticks;
    logic [MAX_W-1:0]     max_msgs;
    bit                   slot_live [NUM_SLOTS];
    logic [TIME_BITS-1:0] msg_log   [NUM_SLOTS][LOG_DEPTH];
    logic [PTR_W-1:0]     oldest    [NUM_SLOTS];
    logic [FILL_W-1:0]    fill      [NUM_SLOTS];

    verdict_t      expected_verdicts [$];
    directed_row_t plan [$];
    phase_cfg_t    phases [NUM_PHASES];

    int                   fail_count;
    int                   cycle_count;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    logic [TIME_BITS-1:0] tick_now;
    verdict_t             seen;
    verdict_t             owed;

    always #CLK_HALF clk = ~clk;

    function automatic bit is_recent(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] t);
        logic [TIME_BITS-1:0] age;
        age = now - t;
        return age <= win_ticks;
    endfunction

    function automatic verdict_t limiter_predict(req_t op, logic [SLOT_W-1:0] s,
                                                 logic [TIME_BITS-1:0] now);
        verdict_t             v;
        logic [PTR_W-1:0]     pos;
        logic [TIME_BITS-1:0] t;
        int                   i;
        int                   k;
        int                   kept;
        v = '0;
        v.present = slot_live[s];
        case (op)
            REQ_RECORD:
            begin
                if (!slot_live[s])
                begin
                    slot_live[s] = 1'b1;
                    oldest[s] = '0;
                    fill[s] = '0;
                end
                if (fill[s] < LOG_DEPTH)
                begin
                    pos = oldest[s] + PTR_W'(fill[s]);
                    msg_log[s][pos] = now;
                    fill[s] = fill[s] + 1'b1;
                end
                else
                begin
                    // overwrite the oldest time and advance past it
                    msg_log[s][oldest[s]] = now;
                    oldest[s] = oldest[s] + 1'b1;
                end
            end
            REQ_CHECK:
            begin
                if (slot_live[s])
                begin
                    for (k = 0; k < fill[s]; k++)
                    begin
                        pos = oldest[s] + PTR_W'(k);
                        if (is_recent(now, msg_log[s][pos]))
                            v.count = v.count + 1'b1;
                    end
                    v.limited = (v.count >= max_msgs);
                end
            end
            REQ_REMOVE:
            begin
                slot_live[s] = 1'b0;
                oldest[s] = '0;
                fill[s] = '0;
            end
            REQ_CLEANUP:
            begin
                for (i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_live[i])
                    begin
                        kept = 0;
                        // compact in place, keeping the order of surviving times
                        for (k = 0; k < fill[i]; k++)
                        begin
                            t = msg_log[i][oldest[i] + PTR_W'(k)];
                            if (is_recent(now, t))
                            begin
                                msg_log[i][oldest[i] + PTR_W'(kept)] = t;
                                kept++;
                            end
                        end
                        fill[i] = FILL_W'(kept);
                    end
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic [TIME_BITS-1:0] time_step();
        logic [TIME_BITS-1:0] span;
        int                   roll;
        span = win_ticks >> 4;
        if (span > 32'd1_000_000)
            span = 32'd1_000_000;
        if (span < 32'd4)
            span = 32'd4;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return $urandom_range(0, 2);
        if (roll < 85)
            return $urandom_range(0, span);
        if (roll < 97)
            return $urandom_range(0, span * 24);
        return $urandom();
    endfunction

    function automatic void add_row(req_t op, logic [SLOT_W-1:0] s, logic [TIME_BITS-1:0] now,
                                    bit typed, logic lim, logic [FILL_W-1:0] cnt, logic pres);
        directed_row_t r;
        r.op = op;
        r.slot = s;
        r.now = now;
        r.typed = typed;
        r.want.limited = lim;
        r.want.count = cnt;
        r.want.present = pres;
        plan.insert(plan.size(), r);
    endfunction

    task automatic report_fault(string what, verdict_t want, verdict_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%0t: %s: expected limited=%0b count=%0d present=%0b",
                     $time, what, want.limited, want.count, want.present);
            $display("    got limited=%0b count=%0d present=%0b",
                     got.limited, got.count, got.present);
        end
    endtask

    task automatic apb_write(logic reg_idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(reg_idx) << CFG_IDX_BIT;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_limits(logic [WIN_W-1:0] window, logic [MAX_W-1:0] limit);
        apb_write(REG_WINDOW_TICKS, CFG_DATA_W'(window));
        win_ticks = window;
        apb_write(REG_MAX_MESSAGES, CFG_DATA_W'(limit));
        max_msgs = limit;
    endtask

    // Drop valid and hold until every outstanding response has come back
    task automatic hold_until_drained();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_request(req_t op, logic [SLOT_W-1:0] s, logic [TIME_BITS-1:0] now,
                                bit typed, verdict_t want);
        verdict_t guess;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= op;
        req_if.client_slot <= s;
        req_if.now_ticks <= now;
        do @(posedge clk); while (!req_if.ready);
        guess = limiter_predict(op, s, now);
        expected_verdicts.insert(expected_verdicts.size(), typed ? want : guess);
    endtask

    always @(negedge clk)
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            seen.limited = rsp_if.limited;
            seen.count = rsp_if.in_window_count;
            seen.present = rsp_if.entry_present;
            if (expected_verdicts.size() == 0)
            begin
                report_fault("response with none outstanding", '0, seen);
            end
            else
            begin
                owed = expected_verdicts.pop_front();
                if (seen.limited !== owed.limited || seen.count !== owed.count ||
                    seen.present !== owed.present)
                    report_fault("response mismatch", owed, seen);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                p;
        int                n;
        int                roll;
        int                burst_left;
        logic [SLOT_W-1:0] burst_slot;
        logic [SLOT_W-1:0] s;
        req_t              op;

        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_RECORD;
        req_if.client_slot = '0;
        req_if.now_ticks = '0;
        rsp_if.ready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 36;
        recv_idle_pct = 51;

        win_ticks = 32'd1000;
        max_msgs = 7'd10;
        for (n = 0; n < NUM_SLOTS; n++)
        begin
            slot_live[n] = 1'b0;
            oldest[n] = '0;
            fill[n] = '0;
        end

        phases[0] = '{32'd5000,       7'd64,  36, 51};
        phases[1] = '{32'd0,          7'd0,   36, 51};
        phases[2] = '{32'hFFFF_FFFF,  7'd127, 51, 36};
        phases[3] = '{32'd300,        7'd3,   51, 36};
        phases[4] = '{32'd1,          7'd1,   0,  0};
        phases[5] = '{32'd20000,      7'd65,  0,  0};

        // Directed rows run with the reset limits: window 1000, max 10
        add_row(REQ_CHECK,   4'd0,  32'd0,    1'b1, 1'b0, 7'd0,  1'b0);
        add_row(REQ_REMOVE,  4'd5,  32'd0,    1'b1, 1'b0, 7'd0,  1'b0);
        add_row(REQ_CLEANUP, 4'd15, 32'd0,    1'b1, 1'b0, 7'd0,  1'b0);
        add_row(REQ_RECORD,  4'd0,  32'd0,    1'b1, 1'b0, 7'd0,  1'b0);
        add_row(REQ_RECORD,  4'd0,  32'd0,    1'b1, 1'b0, 7'd0,  1'b1);
        add_row(REQ_CHECK,   4'd0,  32'd1000, 1'b1, 1'b0, 7'd2,  1'b1);
        add_row(REQ_CHECK,   4'd0,  32'd1001, 1'b1, 1'b0, 7'd0,  1'b1);
        add_row(REQ_RECORD,  4'd15, 32'd1001, 1'b1, 1'b0, 7'd0,  1'b0);
        for (n = 1002; n <= 1010; n++)
            add_row(REQ_RECORD, 4'd15, n, 1'b0, 1'b0, 7'd0, 1'b0);
        add_row(REQ_CHECK,   4'd15, 32'd1010, 1'b1, 1'b1, 7'd10, 1'b1);
        add_row(REQ_CLEANUP, 4'd0,  32'd1500, 1'b1, 1'b0, 7'd0,  1'b1);
        add_row(REQ_CHECK,   4'd0,  32'd1500, 1'b1, 1'b0, 7'd0,  1'b1);
        add_row(REQ_REMOVE,  4'd15, 32'd1500, 1'b1, 1'b0, 7'd0,  1'b1);
        add_row(REQ_CHECK,   4'd15, 32'd1500, 1'b1, 1'b0, 7'd0,  1'b0);
        add_row(REQ_RECORD,  4'd15, 32'hFFFF_FFFF, 1'b1, 1'b0, 7'd0, 1'b0);
        add_row(REQ_CHECK,   4'd15, 32'd999,  1'b1, 1'b0, 7'd1,  1'b1);
        add_row(REQ_CHECK,   4'd15, 32'd1000, 1'b1, 1'b0, 7'd0,  1'b1);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_request(plan[i].op, plan[i].slot, plan[i].now, plan[i].typed, plan[i].want);
        tick_now = plan[plan.size() - 1].now;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            hold_until_drained();
            set_limits(phases[p].window, phases[p].max_msgs);
            send_idle_pct = phases[p].send_idle;
            recv_idle_pct = phases[p].recv_idle;
            // a burst of records to one slot, interleaved with other traffic
            burst_slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
            burst_left = $urandom_range(40, 70);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ((p == 1 && n == PHASE_ITEMS / 2) || $urandom_range(0, 63) == 0)
                    hold_until_drained();
                tick_now = tick_now + time_step();
                roll = $urandom_range(0, 99);
                if (burst_left > 0 && roll < 75)
                begin
                    op = REQ_RECORD;
                    s = burst_slot;
                    burst_left--;
                end
                else
                begin
                    roll = $urandom_range(0, 99);
                    op = (roll < 40) ? REQ_RECORD :
                         (roll < 85) ? REQ_CHECK :
                         (roll < 96) ? REQ_REMOVE : REQ_CLEANUP;
                    s = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
                    if (op != REQ_REMOVE && $urandom_range(0, 1) == 1)
                        s = burst_slot;
                end
                send_request(op, s, tick_now, 1'b0, '0);
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_verdicts.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
